[sv/two_axis_stepper_ramp_generator_top_defines.svh]
// ----------------------------------------------------------------------------
// Stepper ramp generator assertion macros
// Shared property wrappers for the top-level checks.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_STEPPER_RAMP_GENERATOR_TOP_DEFINES_SVH
`define TWO_AXIS_STEPPER_RAMP_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define STPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define STPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/stpr_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper ramp generator package
// Widths, ramp constants, register indexes and shared structs.
// ----------------------------------------------------------------------------
package stpr_pkg;

  localparam int STEP_COUNT_WIDTH = 24;
  localparam int POS_W            = 9;
  localparam int Y_POS_W          = 7;
  localparam int CFG_W            = 16;
  localparam int HALF_W           = 16;
  localparam int RAMP_W           = 8;
  localparam int DELTA_W          = 4;
  localparam int Q_FRAC           = 8;
  localparam int PROD_W           = POS_W + CFG_W;
  localparam int STEPS_RAW_W      = PROD_W - Q_FRAC;

  localparam logic [POS_W-1:0]   X_MAX_DEG    = 9'd350;
  localparam logic [Y_POS_W-1:0] Y_MAX_DEG    = 7'd89;
  localparam logic [POS_W-1:0]   SHORT_MOVE   = 9'd8;
  localparam logic [RAMP_W-1:0]  SHORT_RAMP   = 8'd20;
  localparam logic [DELTA_W-1:0] SHORT_DELTA  = 4'd10;
  localparam logic [HALF_W:0]    SHORT_OFFSET = 17'd400;
  localparam logic [RAMP_W-1:0]  LONG_RAMP    = 8'd200;
  localparam logic [DELTA_W-1:0] LONG_DELTA   = 4'd1;

  localparam logic [CFG_W-1:0] SPD_RESET  = 16'd256;
  localparam logic [CFG_W-1:0] BASE_RESET = 16'd300;

  typedef enum logic [1:0] {
    CFG_X_SPD  = 2'd0,
    CFG_Y_SPD  = 2'd1,
    CFG_X_BASE = 2'd2,
    CFG_Y_BASE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] x_spd;
    logic [CFG_W-1:0] y_spd;
    logic [CFG_W-1:0] x_base;
    logic [CFG_W-1:0] y_base;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic setup;
  } axis_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             pin;
    logic             dir;
    logic [POS_W-1:0] pos;
  } axis_stat_t;

endpackage

[sv/stpr_cfg.sv]
// ----------------------------------------------------------------------------
// Stepper ramp generator configuration registers
// Calibration and cruise-speed registers behind a plain write port.
// ----------------------------------------------------------------------------
module stpr_cfg import stpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.x_spd  <= SPD_RESET;
      regs.y_spd  <= SPD_RESET;
      regs.x_base <= BASE_RESET;
      regs.y_base <= BASE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_SPD:  regs.x_spd  <= cfg_data;
        CFG_Y_SPD:  regs.y_spd  <= cfg_data;
        CFG_X_BASE: regs.x_base <= cfg_data;
        CFG_Y_BASE: regs.y_base <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[sv/stpr_axis.sv]
// ----------------------------------------------------------------------------
// Stepper ramp generator axis
// Move set-up, trapezoidal half-period ramp and step pulse timing for one axis.
// ----------------------------------------------------------------------------
module stpr_axis import stpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  axis_ctl_t        ctl,
  input  logic [POS_W-1:0] tgt,
  input  logic [CFG_W-1:0] spd,
  input  logic [CFG_W-1:0] base,
  output axis_stat_t       stat,
  output axis_stat_t       stat_next
);

  localparam int SCW = STEP_COUNT_WIDTH;

  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   pend, pend_next;
  logic [SCW-1:0]     total, total_next;
  logic [SCW-1:0]     done, done_next;
  logic [RAMP_W-1:0]  rlen, rlen_next;
  logic [DELTA_W-1:0] rdelta, rdelta_next;
  logic [HALF_W-1:0]  half, half_next;
  logic [HALF_W-1:0]  tcnt, tcnt_next;
  logic               pin, pin_next;
  logic               dir, dir_next;

  logic [POS_W-1:0]   deg;
  logic [PROD_W-1:0]  prod;
  logic [SCW-1:0]     steps;
  logic [HALF_W:0]    slow_sum;
  logic [HALF_W-1:0]  half_init;
  logic [SCW-1:0]     done_inc;

  // Drop the half period on the way up, raise it on the way down.
  function automatic logic [HALF_W-1:0] ramp_half(
    input logic [HALF_W-1:0]  h,
    input logic [SCW-1:0]     n,
    input logic [SCW-1:0]     t,
    input logic [RAMP_W-1:0]  r,
    input logic [DELTA_W-1:0] d
  );
    logic [SCW-1:0]    left;
    logic [HALF_W:0]   sum;
    logic [HALF_W:0]   floor_lim;
    logic [HALF_W-1:0] res;
    left      = t - n;
    sum       = {1'b0, h} + {{(HALF_W + 1 - DELTA_W){1'b0}}, d};
    floor_lim = {{(HALF_W + 1 - DELTA_W){1'b0}}, d} + {{HALF_W{1'b0}}, 1'b1};
    res       = h;
    if (n < {{(SCW - RAMP_W){1'b0}}, r}) begin
      if ({1'b0, h} > floor_lim) begin
        res = h - {{(HALF_W - DELTA_W){1'b0}}, d};
      end else begin
        res = {{(HALF_W - 1){1'b0}}, 1'b1};
      end
    end else if (left < {{(SCW - RAMP_W){1'b0}}, r}) begin
      res = sum[HALF_W] ? {HALF_W{1'b1}} : sum[HALF_W-1:0];
    end
    return res;
  endfunction

  assign deg      = (pos < tgt) ? (tgt - pos) : (pos - tgt);
  assign prod     = {{CFG_W{1'b0}}, deg} * {{POS_W{1'b0}}, spd};
  assign steps    = {{(SCW - STEPS_RAW_W){1'b0}}, prod[PROD_W-1:Q_FRAC]};
  assign slow_sum = {1'b0, base} + SHORT_OFFSET;
  assign done_inc = done + {{(SCW - 1){1'b0}}, 1'b1};

  always_comb begin
    if (deg < SHORT_MOVE) begin
      half_init = slow_sum[HALF_W] ? {HALF_W{1'b1}} : slow_sum[HALF_W-1:0];
    end else begin
      half_init = base;
    end
    if (half_init == '0) begin
      half_init = {{(HALF_W - 1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    pos_next    = pos;
    pend_next   = pend;
    total_next  = total;
    done_next   = done;
    rlen_next   = rlen;
    rdelta_next = rdelta;
    half_next   = half;
    tcnt_next   = tcnt;
    pin_next    = pin;
    dir_next    = dir;
    if (ctl.setup) begin
      dir_next    = (pos < tgt);
      pend_next   = tgt;
      total_next  = steps;
      done_next   = '0;
      tcnt_next   = '0;
      pin_next    = 1'b0;
      rlen_next   = (deg < SHORT_MOVE) ? SHORT_RAMP : LONG_RAMP;
      rdelta_next = (deg < SHORT_MOVE) ? SHORT_DELTA : LONG_DELTA;
      half_next   = half_init;
      if (steps == '0) begin
        pos_next = tgt;
      end
    end else if (ctl.tick && (done < total)) begin
      if (tcnt == '0) begin
        half_next = ramp_half(half, done, total, rlen, rdelta);
        pin_next  = 1'b1;
        tcnt_next = {{(HALF_W - 1){1'b0}}, 1'b1};
      end else if (tcnt < half) begin
        tcnt_next = tcnt + {{(HALF_W - 1){1'b0}}, 1'b1};
      end else if (pin) begin
        pin_next  = 1'b0;
        tcnt_next = {{(HALF_W - 1){1'b0}}, 1'b1};
      end else begin
        done_next = done_inc;
        if (done_inc < total) begin
          half_next = ramp_half(half, done_inc, total, rlen, rdelta);
          pin_next  = 1'b1;
          tcnt_next = {{(HALF_W - 1){1'b0}}, 1'b1};
        end else begin
          tcnt_next = '0;
          pos_next  = pend;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      pend   <= '0;
      total  <= '0;
      done   <= '0;
      rlen   <= '0;
      rdelta <= '0;
      half   <= '0;
      tcnt   <= '0;
      pin    <= 1'b0;
      dir    <= 1'b1;
    end else begin
      pos    <= pos_next;
      pend   <= pend_next;
      total  <= total_next;
      done   <= done_next;
      rlen   <= rlen_next;
      rdelta <= rdelta_next;
      half   <= half_next;
      tcnt   <= tcnt_next;
      pin    <= pin_next;
      dir    <= dir_next;
    end
  end

  assign stat.busy      = (done < total);
  assign stat.pin       = pin;
  assign stat.dir       = dir;
  assign stat.pos       = pos;
  assign stat_next.busy = (done_next < total_next);
  assign stat_next.pin  = pin_next;
  assign stat_next.dir  = dir_next;
  assign stat_next.pos  = pos_next;

endmodule

[sv/two_axis_stepper_ramp_generator_top.sv]
// Each accepted word is a single pass through the axis next-state logic; the output register
// holds its result in the next cycle. Throughput: one word per cycle while results are taken.
// The output register frees in_ready whenever the pending result is taken in the same cycle.
// Reset (rst, synchronous): positions 0, axes idle, pins low, directions high,
// steps per degree 1.0 (256 in Q8.8), base half period 300, output register empty.
// ----------------------------------------------------------------------------
// Two-axis stepper ramp generator
// Decodes tick and move words, runs both axes concurrently, registers results.
// ----------------------------------------------------------------------------
`include "two_axis_stepper_ramp_generator_top_defines.svh"

module two_axis_stepper_ramp_generator_top import stpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [POS_W-1:0]   target_x,
  input  logic [Y_POS_W-1:0] target_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               step_x,
  output logic               dir_x,
  output logic               step_y,
  output logic               dir_y,
  output logic               busy_res,
  output logic               accepted,
  output logic [POS_W-1:0]   position_x,
  output logic [Y_POS_W-1:0] position_y,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t       cfg;
  axis_ctl_t  ctl_x, ctl_y;
  axis_stat_t stat_x, stat_y, next_x, next_y;

  logic               take;
  logic               any_busy;
  logic [POS_W-1:0]   tx;
  logic [POS_W-1:0]   ty;
  logic               move_x, move_y;
  logic               accept_move;

  stpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign any_busy = stat_x.busy || stat_y.busy;

  // Out-of-range targets hold the axis where it is.
  assign tx = (target_x > X_MAX_DEG) ? stat_x.pos : target_x;
  assign ty = (target_y > Y_MAX_DEG) ? stat_y.pos
                                     : {{(POS_W - Y_POS_W){1'b0}}, target_y};

  assign move_x      = take && command && !any_busy && (tx != stat_x.pos);
  assign move_y      = take && command && !any_busy && (ty != stat_y.pos);
  assign accept_move = move_x || move_y;

  assign ctl_x.tick  = take && !command;
  assign ctl_x.setup = move_x;
  assign ctl_y.tick  = take && !command;
  assign ctl_y.setup = move_y;

  stpr_axis u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_x),
    .tgt       (tx),
    .spd       (cfg.x_spd),
    .base      (cfg.x_base),
    .stat      (stat_x),
    .stat_next (next_x)
  );

  stpr_axis u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_y),
    .tgt       (ty),
    .spd       (cfg.y_spd),
    .base      (cfg.y_base),
    .stat      (stat_y),
    .stat_next (next_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the state after this word along with the result word.
  always_ff @(posedge clk) begin
    if (take) begin
      step_x     <= next_x.pin;
      dir_x      <= next_x.dir;
      step_y     <= next_y.pin;
      dir_y      <= next_y.dir;
      busy_res   <= next_x.busy || next_y.busy;
      accepted   <= accept_move;
      position_x <= next_x.pos;
      position_y <= next_y.pos[Y_POS_W-1:0];
    end
  end

  `STPR_ASSERT_NXT(a_tick_not_accepted, take && !command, out_valid && !accepted, "tick word reported as accepted move")
  `STPR_ASSERT_NXT(a_busy_move_dropped, take && command && any_busy, !accepted, "move accepted while busy")
  `STPR_ASSERT_IMP(a_idle_pins_low, out_valid && !busy_res, !step_x && !step_y, "step pin high while idle")
  `STPR_ASSERT_IMP(a_pos_range, out_valid, (position_x <= X_MAX_DEG) && (position_y <= Y_MAX_DEG), "position out of range")

endmodule
